@@ hw/rtl/ptm_pkg.sv @@
// Shared constants, register codes and constant functions of the pixel tone mapper.
`timescale 1ns / 1ps

package ptm_pkg;

    // Internal fixed point: unsigned with FRAC_W fraction bits.
    localparam int FRAC_W = 16;
    localparam int ONE_W  = FRAC_W + 1;
    localparam int INT_W  = FRAC_W + 8;
    localparam logic [ONE_W-1:0] ONE  = ONE_W'(1) << FRAC_W;
    localparam logic [INT_W-1:0] MAXV = '1;

    // Rec. 709 luminance weights rounded to FRAC_W fraction bits.
    localparam int KR = ((2126 << FRAC_W) + 5000) / 10000;
    localparam int KG = ((7152 << FRAC_W) + 5000) / 10000;
    localparam int KB = ((722 << FRAC_W) + 5000) / 10000;

    // Stages inside one gamma channel, from its input register to its output byte.
    localparam int CHAN_LAT = 2 * FRAC_W + 4;

    localparam int CFG_W  = 16;
    localparam int ADDR_W = 3;

    typedef enum logic [ADDR_W-1:0] {
        REG_RED_GAIN      = 3'd0,
        REG_GREEN_GAIN    = 3'd1,
        REG_BLUE_GAIN     = 3'd2,
        REG_EXPOSURE_GAIN = 3'd3,
        REG_WHITE_POINT   = 3'd4,
        REG_INVERSE_GAMMA = 3'd5
    } cfg_idx_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b_m;
        logic [63:0] vv;
        res = '0;
        b_m = 64'h4000_0000_0000_0000;
        vv  = v;
        while (b_m > vv) b_m = b_m >> 2;
        while (b_m != 0) begin
            if (vv >= res + b_m) begin
                vv  = vv - (res + b_m);
                res = (res >> 1) + b_m;
            end else begin
                res = res >> 1;
            end
            b_m = b_m >> 2;
        end
        return res;
    endfunction

    // Value 2^-(2^-idx) in FRAC_W fraction bits, by repeated floor square roots.
    function automatic logic [FRAC_W-1:0] exp_root(input int idx);
        logic [63:0] q;
        q = isqrt64(64'd1 << (2 * FRAC_W - 1));
        for (int k = 1; k < idx; k++) q = isqrt64(q << FRAC_W);
        return q[FRAC_W-1:0];
    endfunction

endpackage

@@ hw/rtl/ptm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with saturation flag.
`timescale 1ns / 1ps

module ptm_div #(
    parameter int NW = 40,
    parameter int DW = 32,
    parameter int QW = 24,
    parameter int PW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic          in_sat,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [PW-1:0] out_pay
);

    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic [W-1:0]  rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [1:QW];
    logic          sat_reg [QW+1];
    logic [PW-1:0] pay_reg [QW+1];
    logic          vld_reg [QW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= W'(in_num);
            den_reg[0] <= in_den;
            sat_reg[0] <= in_sat;
            pay_reg[0] <= in_pay;
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_stage
        localparam int K = QW - j;
        logic [W-1:0] dsh;
        logic         ge;

        always_comb begin
            dsh = W'(den_reg[j-1]) << K;
            ge  = rem_reg[j-1] >= dsh;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sat_reg[j] <= sat_reg[j-1];
                pay_reg[j] <= pay_reg[j-1];
            end
        end

        if (j == 1) begin : g_first
            always_ff @(posedge aclk) begin
                if (en) quo_reg[j] <= QW'(ge);
            end
        end else begin : g_rest
            always_ff @(posedge aclk) begin
                if (en) quo_reg[j] <= {quo_reg[j-1][QW-2:0], ge};
            end
        end

        if (j < QW) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= ge ? rem_reg[j-1] - dsh : rem_reg[j-1];
                    den_reg[j] <= den_reg[j-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_quo   = sat_reg[QW] ? '1 : quo_reg[QW];
    assign out_pay   = pay_reg[QW];

endmodule

@@ hw/rtl/ptm_chan.sv @@
// One color channel: -log2 by repeated squaring, exponent product, exp2 by root table.
`timescale 1ns / 1ps

module ptm_chan
    import ptm_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [CFG_W-1:0] gamma_exp,
    input  logic [ONE_W-1:0] x_in,
    output logic [7:0]       y_out
);

    // Log stages.
    logic [ONE_W-1:0]  m_reg    [FRAC_W+1];
    logic [FRAC_W-1:0] frac_reg [FRAC_W+1];
    logic [4:0]        ip_reg   [FRAC_W+1];
    logic              zero_reg [FRAC_W+1];

    // Exp stages.
    logic [ONE_W-1:0]  r_reg    [FRAC_W+1];
    logic [FRAC_W-1:0] f_reg    [FRAC_W+1];
    logic [4:0]        n_reg    [FRAC_W+1];
    logic              kill_reg [FRAC_W+1];

    logic [ONE_W-1:0] y_reg;
    logic             ykill_reg;
    logic [7:0]       out_reg;

    logic [4:0]       pos;
    logic [4:0]       ip_next;
    logic [ONE_W-1:0] m_next;

    // The leading one sets the integer part; the mantissa is left aligned to [1,2).
    always_comb begin
        pos = 5'd0;
        for (int k = 1; k < ONE_W; k++) begin
            if (x_in[k]) pos = 5'(k);
        end
        ip_next = 5'(FRAC_W) - pos;
        m_next  = x_in << ip_next;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0]    <= m_next;
            frac_reg[0] <= '0;
            ip_reg[0]   <= ip_next;
            zero_reg[0] <= (x_in == '0);
        end
    end

    for (genvar i = 1; i <= FRAC_W; i++) begin : g_sq
        logic [2*ONE_W-1:0] mm;
        logic [ONE_W:0]     sq;

        always_comb begin
            mm = (2*ONE_W)'(m_reg[i-1]) * (2*ONE_W)'(m_reg[i-1]);
            sq = mm[2*ONE_W-1:FRAC_W];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[i]    <= sq[ONE_W] ? sq[ONE_W:1] : sq[ONE_W-1:0];
                frac_reg[i] <= {frac_reg[i-1][FRAC_W-2:0], sq[ONE_W]};
                ip_reg[i]   <= ip_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
            end
        end
    end

    logic [FRAC_W+4:0]  nl;
    logic [FRAC_W+20:0] tp;
    logic [FRAC_W+8:0]  t;

    always_comb begin
        nl = {ip_reg[FRAC_W], FRAC_W'(0)} - (FRAC_W+5)'(frac_reg[FRAC_W]);
        tp = (FRAC_W+21)'(nl) * (FRAC_W+21)'(gamma_exp) + (FRAC_W+21)'(2048);
        t  = tp[FRAC_W+20:12];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]    <= ONE;
            f_reg[0]    <= t[FRAC_W-1:0];
            n_reg[0]    <= t[FRAC_W+4:FRAC_W];
            kill_reg[0] <= zero_reg[FRAC_W] || (t[FRAC_W+8:FRAC_W] > 9'(FRAC_W));
        end
    end

    for (genvar i = 1; i <= FRAC_W; i++) begin : g_exp
        localparam logic [FRAC_W-1:0] Q = exp_root(i);
        logic [ONE_W+FRAC_W-1:0] pr;

        always_comb begin
            pr = (ONE_W+FRAC_W)'(r_reg[i-1]) * (ONE_W+FRAC_W)'(Q)
                 + (ONE_W+FRAC_W)'(ONE >> 1);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[i]    <= f_reg[i-1][FRAC_W-i] ? pr[ONE_W+FRAC_W-1:FRAC_W]
                                                    : r_reg[i-1];
                f_reg[i]    <= f_reg[i-1];
                n_reg[i]    <= n_reg[i-1];
                kill_reg[i] <= kill_reg[i-1];
            end
        end
    end

    logic [ONE_W:0]   rsum;
    logic [ONE_W:0]   rsh;
    logic [ONE_W-1:0] y_next;

    // Integer part of the exponent: shift right with rounding half up.
    always_comb begin
        if (n_reg[FRAC_W] != 5'd0) begin
            rsum = (ONE_W+1)'(r_reg[FRAC_W])
                   + ((ONE_W+1)'(1) << (n_reg[FRAC_W] - 5'd1));
            rsh  = rsum >> n_reg[FRAC_W];
        end else begin
            rsum = (ONE_W+1)'(r_reg[FRAC_W]);
            rsh  = rsum;
        end
        y_next = (rsh > (ONE_W+1)'(ONE)) ? ONE : rsh[ONE_W-1:0];
    end

    logic [INT_W:0] pb;

    always_comb begin
        pb = (INT_W+1)'(y_reg) * (INT_W+1)'(255) + (INT_W+1)'(ONE >> 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg     <= y_next;
            ykill_reg <= kill_reg[FRAC_W];
            out_reg   <= ykill_reg ? 8'd0 : pb[FRAC_W+7:FRAC_W];
        end
    end

    assign y_out = out_reg;

endmodule

@@ hw/rtl/pixel_tone_mapper_unit.sv @@
// Top level of the pixel tone mapper: front gains, luminance, Reinhard scale and gamma.
`timescale 1ns / 1ps

// Usage:
// Pixels enter on the s_ stream channel (one BGR word plus tlast per beat) and
// leave on the m_ channel in the same order, one result word for every input word.
// The whole datapath is one pipeline of 93 register stages that advances or
// freezes as a whole. A new word is taken in every cycle unless the output is
// stalled, so the throughput is one pixel per clock while nothing stalls.
// The depth is set by the two pipelined dividers (25 stages each, one quotient
// bit per stage) and by the 16-step squaring and 16-step root chains of the
// gamma units.
// When the receiver holds m_tready low while m_tvalid is high, the entire
// pipeline freezes and s_tready drops in the same cycle; nothing is lost.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata while
// the stream is idle; writes to unused indexes are ignored.
// A synchronous low aresetn empties the pipeline and restores the register
// defaults (unity gains, white point 4.0, inverse gamma of about 1/2.2).

module pixel_tone_mapper_unit
    import ptm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // blue_in[7:0], green_in[15:8], red_in[23:16]
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // blue_out[7:0], green_out[15:8], red_out[23:16]
    output logic              m_tlast,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int DPW = 4 * INT_W + 1;

    logic adv;

    logic [CFG_W-1:0] red_gain_reg, green_gain_reg, blue_gain_reg;
    logic [CFG_W-1:0] exposure_reg, white_reg, gamma_exp_reg;
    logic [31:0]      w2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_gain_reg   <= 16'd4096;
            green_gain_reg <= 16'd4096;
            blue_gain_reg  <= 16'd4096;
            exposure_reg   <= 16'd256;
            white_reg      <= 16'd1024;
            gamma_exp_reg  <= 16'd1862;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_RED_GAIN:      red_gain_reg   <= cfg_wdata;
                REG_GREEN_GAIN:    green_gain_reg <= cfg_wdata;
                REG_BLUE_GAIN:     blue_gain_reg  <= cfg_wdata;
                REG_EXPOSURE_GAIN: exposure_reg   <= cfg_wdata;
                REG_WHITE_POINT:   white_reg      <= cfg_wdata;
                REG_INVERSE_GAMMA: gamma_exp_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A zero white point counts as the smallest step.
    logic [CFG_W-1:0] w_eff;
    assign w_eff = (white_reg == '0) ? CFG_W'(1) : white_reg;

    always_ff @(posedge aclk) begin
        w2_reg <= 32'(w_eff) * 32'(w_eff);
    end

    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Lanes: 0 blue, 1 green, 2 red.
    logic [CFG_W-1:0] gain [3];
    assign gain[0] = blue_gain_reg;
    assign gain[1] = green_gain_reg;
    assign gain[2] = red_gain_reg;

    logic [INT_W-1:0] kw [3];
    assign kw[0] = INT_W'(KB);
    assign kw[1] = INT_W'(KG);
    assign kw[2] = INT_W'(KR);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic l1_reg, l2_reg, l3_reg, l4_reg, l5_reg;
    logic [ONE_W-1:0]   x0_reg [3];
    logic [20:0]        x1_reg [3];
    logic [INT_W-1:0]   x2_reg [3];
    logic [INT_W-1:0]   x3_reg [3];
    logic [INT_W-1:0]   x4_reg [3];
    logic [2*INT_W-9:0] pr_reg [3];
    logic [INT_W-1:0]   lum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    logic [32:0]          g1 [3];
    logic [36:0]          g2 [3];
    logic [INT_W-1:0]     x2_next [3];
    logic [2*INT_W-7:0]   lsum;
    logic [INT_W-1:0]     lum_next;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            g1[c] = 33'(x0_reg[c]) * 33'(gain[c]) + 33'd2048;
            g2[c] = 37'(x1_reg[c]) * 37'(exposure_reg) + 37'd128;
            x2_next[c] = (g2[c][36:INT_W+8] != '0) ? MAXV : g2[c][INT_W+7:8];
        end
        lsum = (2*INT_W-6)'(pr_reg[0]) + (2*INT_W-6)'(pr_reg[1])
               + (2*INT_W-6)'(pr_reg[2]) + (2*INT_W-6)'(ONE >> 1);
        lum_next = (lsum[2*INT_W-7:FRAC_W+INT_W] != '0) ? MAXV
                                                         : lsum[FRAC_W+INT_W-1:FRAC_W];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            l1_reg <= s_tlast;
            l2_reg <= l1_reg;
            l3_reg <= l2_reg;
            l4_reg <= l3_reg;
            l5_reg <= l4_reg;
            lum_reg <= lum_next;
            for (int c = 0; c < 3; c++) begin
                // in * 2^16 / 255, rounded: in * 257 plus one for the upper half.
                x0_reg[c] <= ONE_W'(s_tdata[8*c +: 8]) * ONE_W'(257)
                             + ONE_W'(s_tdata[8*c+7]);
                x1_reg[c] <= g1[c][32:12];
                x2_reg[c] <= x2_next[c];
                pr_reg[c] <= (2*INT_W-8)'(x2_reg[c]) * (2*INT_W-8)'(kw[c]);
                x3_reg[c] <= x2_reg[c];
                x4_reg[c] <= x3_reg[c];
            end
        end
    end

    // Divider 1: term = L * 2^16 / W^2.
    logic           d1_valid;
    logic [INT_W-1:0] d1_quo;
    logic [DPW-1:0] d1_pay;
    logic           d1_sat;

    assign d1_sat = {16'd0, lum_reg} >= {w2_reg, 8'd0};

    ptm_div #(
        .NW(INT_W + 16),
        .DW(32),
        .QW(INT_W),
        .PW(DPW)
    ) u_div_term (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (v5_reg),
        .in_num   ({lum_reg, 16'd0}),
        .in_den   (w2_reg),
        .in_sat   (d1_sat),
        .in_pay   ({l5_reg, x4_reg[2], x4_reg[1], x4_reg[0], lum_reg}),
        .out_valid(d1_valid),
        .out_quo  (d1_quo),
        .out_pay  (d1_pay)
    );

    // Divider 2: scale = (ONE + term) / (ONE + L), rounded.
    logic [INT_W:0]          den2;
    logic [INT_W+FRAC_W:0]   num2;
    logic                    d2_sat;
    logic                    d2_valid;
    logic [INT_W-1:0]        d2_quo;
    logic [DPW-1:0]          d2_pay;

    always_comb begin
        den2 = (INT_W+1)'(ONE) + (INT_W+1)'(d1_pay[INT_W-1:0]);
        num2 = (((INT_W+FRAC_W+1)'(ONE) + (INT_W+FRAC_W+1)'(d1_quo)) << FRAC_W)
               + (INT_W+FRAC_W+1)'(den2 >> 1);
        d2_sat = (2*INT_W+1)'(num2) >= {den2, INT_W'(0)};
    end

    ptm_div #(
        .NW(INT_W + FRAC_W + 1),
        .DW(INT_W + 1),
        .QW(INT_W),
        .PW(DPW)
    ) u_div_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (d1_valid),
        .in_num   (num2),
        .in_den   (den2),
        .in_sat   (d2_sat),
        .in_pay   (d1_pay),
        .out_valid(d2_valid),
        .out_quo  (d2_quo),
        .out_pay  (d2_pay)
    );

    // Apply the scale; zero luminance leaves the channels as they are.
    logic [INT_W-1:0]   s_fac;
    logic [INT_W-1:0]   ch_in [3];
    logic [2*INT_W-1:0] sp_reg [3];
    logic [ONE_W-1:0]   sc_reg [3];
    logic               va_reg, vb_reg, la_reg, lb_reg;
    logic [2*INT_W:0]   rnd [3];
    logic [ONE_W-1:0]   sc_next [3];

    assign s_fac = (d2_pay[INT_W-1:0] == '0) ? INT_W'(ONE) : d2_quo;
    assign ch_in[0] = d2_pay[2*INT_W-1:INT_W];
    assign ch_in[1] = d2_pay[3*INT_W-1:2*INT_W];
    assign ch_in[2] = d2_pay[4*INT_W-1:3*INT_W];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rnd[c] = (2*INT_W+1)'(sp_reg[c]) + (2*INT_W+1)'(ONE >> 1);
            sc_next[c] = (rnd[c][2*INT_W:FRAC_W] > (2*INT_W-FRAC_W+1)'(ONE))
                         ? ONE : rnd[c][FRAC_W+ONE_W-1:FRAC_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= d2_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            la_reg <= d2_pay[DPW-1];
            lb_reg <= la_reg;
            for (int c = 0; c < 3; c++) begin
                sp_reg[c] <= (2*INT_W)'(ch_in[c]) * (2*INT_W)'(s_fac);
                sc_reg[c] <= sc_next[c];
            end
        end
    end

    logic [7:0] byte_out [3];

    for (genvar c = 0; c < 3; c++) begin : g_chan
        ptm_chan u_chan (
            .aclk     (aclk),
            .en       (adv),
            .gamma_exp(gamma_exp_reg),
            .x_in     (sc_reg[c]),
            .y_out    (byte_out[c])
        );
    end

    logic vd_reg [CHAN_LAT];
    logic ld_reg [CHAN_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CHAN_LAT; k++) vd_reg[k] <= 1'b0;
        end else if (adv) begin
            vd_reg[0] <= vb_reg;
            for (int k = 1; k < CHAN_LAT; k++) vd_reg[k] <= vd_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ld_reg[0] <= lb_reg;
            for (int k = 1; k < CHAN_LAT; k++) ld_reg[k] <= ld_reg[k-1];
        end
    end

    assign m_tvalid = vd_reg[CHAN_LAT-1];
    assign m_tlast  = ld_reg[CHAN_LAT-1];
    assign m_tdata  = {byte_out[2], byte_out[1], byte_out[0]};

endmodule

@@ hw/rtl/ptm_checker.sv @@
// Port-level checks for the pixel tone mapper, bound to the top level.
`timescale 1ns / 1ps

module ptm_checker
    import ptm_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [23:0]       s_tdata,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [23:0]       m_tdata,
    input logic              m_tlast,
    input logic              cfg_we,
    input logic [ADDR_W-1:0] cfg_addr,
    input logic [CFG_W-1:0]  cfg_wdata
);

    // The input side stalls exactly when a result word is stuck at the output.
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output stall");

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word present right after reset");

    // A stalled result word holds its value and its last flag.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    // After reset, the output stays empty past the sample that the reset check above covers.
    a_no_early_word: assert property (@(posedge aclk)
        !aresetn |=> ##1 !m_tvalid)
        else $error("result word appeared too early after reset");

endmodule

bind pixel_tone_mapper_unit ptm_checker u_ptm_checker (.*);
